// ----- hw/rtl/lrcc_pkg.sv -----
package lrcc_pkg;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_CROSS = 2'd1,
      ACT_PASS  = 2'd2
   } action_type;

   // Fixed request field widths
   localparam int REQ_IDX_BITS  = 6;
   localparam int REQ_COORD_BITS = 16;

   // Route end slots: first route a/b, second route a/b (second a is the probe)
   localparam int END_A1   = 0;
   localparam int END_B1   = 1;
   localparam int END_A2   = 2;
   localparam int END_B2   = 3;
   localparam int NUM_ENDS = 4;

   // Leg slots: horizontal and vertical leg of each route
   localparam int LEG_H1   = 0;
   localparam int LEG_V1   = 1;
   localparam int LEG_H2   = 2;
   localparam int LEG_V2   = 3;
   localparam int NUM_LEGS = 4;

   // Per-request control travelling down the pipe
   typedef struct packed {
      action_type action;
      logic       bend_first;
      logic       bend_second;
      logic       shared_a;        // first route start is an end of the second route
      logic       shared_b;        // first route end is an end of the second route
      logic       probe_excluded;  // probe is a route end, by index or by position
   } ctl_type;

   // Comparison results handed to the final stage
   typedef struct packed {
      logic any_cross;
      logic any_touch;
      logic probe_on_leg;
      logic hh_same_line;
      logic vv_same_line;
   } cmp_flags_type;

endpackage

// ----- hw/rtl/lshape_route_crossing_check_unit.sv -----
// L-shaped route conflict checker over a table of node grid positions.
// Request channel (req_valid/req_ready): action LOAD writes node req_first_a
// with req_load_x/req_load_y; CROSS tests the route first_a->first_b against
// second_a->second_b, each an L with its own bend bit; PASS tests whether the
// first route runs over node req_second_a. Every request, loads and the
// unused action code included, gives exactly one response on rsp_valid/
// rsp_ready with rsp_hit (always 0 for a load or the unused code).
// Four register stages (table read, leg build, leg compares, final
// reduce) lie between acceptance and the response. One request per cycle
// is taken unless the receiver stalls the pipe; the two-port table is held
// twice so all four node reads of a query happen in the same cycle.
// A load is visible to the very next request.
// Reset clears the stage valid bits only; the node table keeps no reset
// value, and a query naming a node never loaded returns an undefined hit.
// When the receiver stalls, each stage holds until the one after it frees;
// bubbles are squeezed out, so up to four requests sit in the pipe before
// req_ready drops.
module lshape_route_crossing_check_unit #(
   parameter int MAX_NODES  = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_action,
   input  logic [lrcc_pkg::REQ_IDX_BITS-1:0]         req_first_a,
   input  logic [lrcc_pkg::REQ_IDX_BITS-1:0]         req_first_b,
   input  logic                                      req_first_bend,
   input  logic [lrcc_pkg::REQ_IDX_BITS-1:0]         req_second_a,
   input  logic [lrcc_pkg::REQ_IDX_BITS-1:0]         req_second_b,
   input  logic                                      req_second_bend,
   input  logic signed [lrcc_pkg::REQ_COORD_BITS-1:0] req_load_x,
   input  logic signed [lrcc_pkg::REQ_COORD_BITS-1:0] req_load_y,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_hit
);

   import lrcc_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_NODES);
   localparam int REQ_SPAN  = 2 ** REQ_IDX_BITS;
   localparam int ROW_BITS  = 2 * COORD_BITS;

   // ---------------------------------------------------------------
   // Index wrap: request indices are taken modulo the table depth.
   // Constant lookup, built at elaboration.
   // ---------------------------------------------------------------
   logic [IDX_BITS-1:0] wrap_lut [REQ_SPAN];

   for (genvar g = 0; g < REQ_SPAN; g++) begin : g_wrap
      localparam int WRAPPED = g % MAX_NODES;
      assign wrap_lut[g] = IDX_BITS'(WRAPPED);
   end

   logic [IDX_BITS-1:0] fa, fb, sa, sb;

   assign fa = wrap_lut[req_first_a];
   assign fb = wrap_lut[req_first_b];
   assign sa = wrap_lut[req_second_a];
   assign sb = wrap_lut[req_second_b];

   // ---------------------------------------------------------------
   // Flow control: each stage advances when empty or when the next
   // stage advances.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, rsp_valid_in;
   logic en1, en2, en3, en4;
   logic req_fire;

   assign en4      = !rsp_valid_ff || rsp_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign req_fire = req_valid && en1;

   assign v1_in        = en1 ? req_valid : v1_ff;
   assign v2_in        = en2 ? v1_ff : v2_ff;
   assign v3_in        = en3 ? v2_ff : v3_ff;
   assign rsp_valid_in = en4 ? v3_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: node table write and read, control capture.
   // Load data is sign-extended then cut to the stored width.
   // ---------------------------------------------------------------
   logic signed [31:0]           load_x_ext, load_y_ext;
   logic [ROW_BITS-1:0]          wr_row;
   logic                         wr_en;
   logic [ROW_BITS-1:0]          row_a1, row_b1, row_a2, row_b2;
   ctl_type                      ctl1_ff, ctl1_in;

   assign load_x_ext = 32'(req_load_x);
   assign load_y_ext = 32'(req_load_y);
   assign wr_row     = {load_x_ext[COORD_BITS-1:0], load_y_ext[COORD_BITS-1:0]};
   assign wr_en      = req_fire && (req_action == ACT_LOAD);

   // copy for the first route's ends
   lrcc_node_table #(
      .DEPTH     (MAX_NODES),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (ROW_BITS)
   ) u_table_first (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (fa),
      .wr_data   (wr_row),
      .rd_en     (en1),
      .rd_addr_0 (fa),
      .rd_addr_1 (fb),
      .rd_data_0 (row_a1),
      .rd_data_1 (row_b1)
   );

   // copy for the second route's ends (start doubles as the probe)
   lrcc_node_table #(
      .DEPTH     (MAX_NODES),
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (ROW_BITS)
   ) u_table_second (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (fa),
      .wr_data   (wr_row),
      .rd_en     (en1),
      .rd_addr_0 (sa),
      .rd_addr_1 (sb),
      .rd_data_0 (row_a2),
      .rd_data_1 (row_b2)
   );

   always_comb begin
      ctl1_in.action         = action_type'(req_action);
      ctl1_in.bend_first     = req_first_bend;
      ctl1_in.bend_second    = req_second_bend;
      ctl1_in.shared_a       = (fa == sa) || (fa == sb);
      ctl1_in.shared_b       = (fb == sa) || (fb == sb);
      ctl1_in.probe_excluded = (sa == fa) || (sa == fb);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctl1_ff <= ctl1_in;
      end
   end

   logic signed [COORD_BITS-1:0] end_x1 [NUM_ENDS];
   logic signed [COORD_BITS-1:0] end_y1 [NUM_ENDS];

   assign end_x1[END_A1] = row_a1[ROW_BITS-1:COORD_BITS];
   assign end_y1[END_A1] = row_a1[COORD_BITS-1:0];
   assign end_x1[END_B1] = row_b1[ROW_BITS-1:COORD_BITS];
   assign end_y1[END_B1] = row_b1[COORD_BITS-1:0];
   assign end_x1[END_A2] = row_a2[ROW_BITS-1:COORD_BITS];
   assign end_y1[END_A2] = row_a2[COORD_BITS-1:0];
   assign end_x1[END_B2] = row_b2[ROW_BITS-1:COORD_BITS];
   assign end_y1[END_B2] = row_b2[COORD_BITS-1:0];

   // ---------------------------------------------------------------
   // Stage 2: leg extents per route
   // ---------------------------------------------------------------
   ctl_type                      ctl2;
   logic signed [COORD_BITS-1:0] end_x2 [NUM_ENDS];
   logic signed [COORD_BITS-1:0] end_y2 [NUM_ENDS];
   logic signed [COORD_BITS-1:0] leg_fix2 [NUM_LEGS];
   logic signed [COORD_BITS-1:0] leg_lo2 [NUM_LEGS];
   logic signed [COORD_BITS-1:0] leg_hi2 [NUM_LEGS];

   lrcc_leg_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_legs (
      .clock     (clock),
      .en        (en2),
      .ctl_in    (ctl1_ff),
      .end_x     (end_x1),
      .end_y     (end_y1),
      .ctl_out   (ctl2),
      .end_x_out (end_x2),
      .end_y_out (end_y2),
      .leg_fix   (leg_fix2),
      .leg_lo    (leg_lo2),
      .leg_hi    (leg_hi2)
   );

   // ---------------------------------------------------------------
   // Stage 3: pairwise leg compares, collinear overlap bounds
   // ---------------------------------------------------------------
   ctl_type                      ctl3;
   cmp_flags_type                flags3;
   logic signed [COORD_BITS-1:0] node_x3 [2];
   logic signed [COORD_BITS-1:0] node_y3 [2];
   logic signed [COORD_BITS-1:0] hh_lo3, hh_hi3, vv_lo3, vv_hi3;

   lrcc_compare_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_compare (
      .clock      (clock),
      .en         (en3),
      .ctl_in     (ctl2),
      .end_x      (end_x2),
      .end_y      (end_y2),
      .leg_fix    (leg_fix2),
      .leg_lo     (leg_lo2),
      .leg_hi     (leg_hi2),
      .ctl_out    (ctl3),
      .flags_out  (flags3),
      .node_x_out (node_x3),
      .node_y_out (node_y3),
      .hh_lo_out  (hh_lo3),
      .hh_hi_out  (hh_hi3),
      .vv_lo_out  (vv_lo3),
      .vv_hi_out  (vv_hi3)
   );

   // ---------------------------------------------------------------
   // Stage 4: final verdict.
   // A strict crossing or collinear overlap always counts; with a shared end
   // node nothing else does, without one any perpendicular touch counts too.
   // ---------------------------------------------------------------
   function automatic logic past_node(input logic signed [COORD_BITS-1:0] c,
                                      input logic signed [COORD_BITS-1:0] lo,
                                      input logic signed [COORD_BITS-1:0] hi);
      return (hi > lo) && ((hi > c) || (lo < c));
   endfunction

   logic beyond_a, beyond_b, shared_any, cross_hit, pass_hit;
   logic hit_ff, hit_in;

   assign beyond_a = (flags3.hh_same_line && past_node(node_x3[0], hh_lo3, hh_hi3)) ||
                     (flags3.vv_same_line && past_node(node_y3[0], vv_lo3, vv_hi3));
   assign beyond_b = (flags3.hh_same_line && past_node(node_x3[1], hh_lo3, hh_hi3)) ||
                     (flags3.vv_same_line && past_node(node_y3[1], vv_lo3, vv_hi3));

   assign shared_any = ctl3.shared_a || ctl3.shared_b;
   assign cross_hit  = flags3.any_cross ||
                       (shared_any ? ((ctl3.shared_a && beyond_a) || (ctl3.shared_b && beyond_b))
                                   : flags3.any_touch);
   assign pass_hit   = !ctl3.probe_excluded && flags3.probe_on_leg;

   always_comb begin
      case (ctl3.action)
         ACT_CROSS: hit_in = cross_hit;
         ACT_PASS:  hit_in = pass_hit;
         default:   hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         hit_ff <= hit_in;
      end
   end

   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = hit_ff;

endmodule

// ----- hw/rtl/lrcc_node_table.sv -----
module lrcc_node_table #(
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_0,
   input  logic [ADDR_BITS-1:0] rd_addr_1,
   output logic [DATA_BITS-1:0] rd_data_0,
   output logic [DATA_BITS-1:0] rd_data_1
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd0_ff;
   logic [DATA_BITS-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= mem_ff[rd_addr_0];
         rd1_ff <= mem_ff[rd_addr_1];
      end
   end

   assign rd_data_0 = rd0_ff;
   assign rd_data_1 = rd1_ff;

endmodule

// ----- hw/rtl/lrcc_leg_stage.sv -----
module lrcc_leg_stage #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  lrcc_pkg::ctl_type            ctl_in,
   input  logic signed [COORD_BITS-1:0] end_x [lrcc_pkg::NUM_ENDS],
   input  logic signed [COORD_BITS-1:0] end_y [lrcc_pkg::NUM_ENDS],
   output lrcc_pkg::ctl_type            ctl_out,
   output logic signed [COORD_BITS-1:0] end_x_out [lrcc_pkg::NUM_ENDS],
   output logic signed [COORD_BITS-1:0] end_y_out [lrcc_pkg::NUM_ENDS],
   output logic signed [COORD_BITS-1:0] leg_fix [lrcc_pkg::NUM_LEGS],
   output logic signed [COORD_BITS-1:0] leg_lo [lrcc_pkg::NUM_LEGS],
   output logic signed [COORD_BITS-1:0] leg_hi [lrcc_pkg::NUM_LEGS]
);

   import lrcc_pkg::*;

   ctl_type                      ctl_ff, ctl_next_in;
   logic signed [COORD_BITS-1:0] end_x_ff [NUM_ENDS];
   logic signed [COORD_BITS-1:0] end_y_ff [NUM_ENDS];
   logic signed [COORD_BITS-1:0] fix_ff [NUM_LEGS], fix_in [NUM_LEGS];
   logic signed [COORD_BITS-1:0] lo_ff [NUM_LEGS], lo_in [NUM_LEGS];
   logic signed [COORD_BITS-1:0] hi_ff [NUM_LEGS], hi_in [NUM_LEGS];
   logic                         probe_at_a, probe_at_b;

   // Legs of one route; h at y(a) for bend 0, at y(b) for bend 1;
   // v at x(b) for bend 0, at x(a) for bend 1
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
         logic                         bend;
         xa   = end_x[2*r];
         ya   = end_y[2*r];
         xb   = end_x[2*r+1];
         yb   = end_y[2*r+1];
         bend = (r == 0) ? ctl_in.bend_first : ctl_in.bend_second;
         fix_in[2*r]   = bend ? yb : ya;
         lo_in[2*r]    = (xa < xb) ? xa : xb;
         hi_in[2*r]    = (xa < xb) ? xb : xa;
         fix_in[2*r+1] = bend ? xa : xb;
         lo_in[2*r+1]  = (ya < yb) ? ya : yb;
         hi_in[2*r+1]  = (ya < yb) ? yb : ya;
      end
   end

   assign probe_at_a = (end_x[END_A2] == end_x[END_A1]) && (end_y[END_A2] == end_y[END_A1]);
   assign probe_at_b = (end_x[END_A2] == end_x[END_B1]) && (end_y[END_A2] == end_y[END_B1]);

   always_comb begin
      ctl_next_in = ctl_in;
      ctl_next_in.probe_excluded = ctl_in.probe_excluded | probe_at_a | probe_at_b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff   <= ctl_next_in;
         end_x_ff <= end_x;
         end_y_ff <= end_y;
         fix_ff   <= fix_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign end_x_out = end_x_ff;
   assign end_y_out = end_y_ff;
   assign leg_fix   = fix_ff;
   assign leg_lo    = lo_ff;
   assign leg_hi    = hi_ff;

endmodule

// ----- hw/rtl/lrcc_compare_stage.sv -----
module lrcc_compare_stage #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  lrcc_pkg::ctl_type            ctl_in,
   input  logic signed [COORD_BITS-1:0] end_x [lrcc_pkg::NUM_ENDS],
   input  logic signed [COORD_BITS-1:0] end_y [lrcc_pkg::NUM_ENDS],
   input  logic signed [COORD_BITS-1:0] leg_fix [lrcc_pkg::NUM_LEGS],
   input  logic signed [COORD_BITS-1:0] leg_lo [lrcc_pkg::NUM_LEGS],
   input  logic signed [COORD_BITS-1:0] leg_hi [lrcc_pkg::NUM_LEGS],
   output lrcc_pkg::ctl_type            ctl_out,
   output lrcc_pkg::cmp_flags_type      flags_out,
   output logic signed [COORD_BITS-1:0] node_x_out [2],
   output logic signed [COORD_BITS-1:0] node_y_out [2],
   output logic signed [COORD_BITS-1:0] hh_lo_out,
   output logic signed [COORD_BITS-1:0] hh_hi_out,
   output logic signed [COORD_BITS-1:0] vv_lo_out,
   output logic signed [COORD_BITS-1:0] vv_hi_out
);

   import lrcc_pkg::*;

   ctl_type                      ctl_ff;
   cmp_flags_type                flags_ff, flags_in;
   logic signed [COORD_BITS-1:0] node_x_ff [2];
   logic signed [COORD_BITS-1:0] node_y_ff [2];
   logic signed [COORD_BITS-1:0] hh_lo_ff, hh_hi_ff, vv_lo_ff, vv_hi_ff;
   logic signed [COORD_BITS-1:0] hh_lo_in, hh_hi_in, vv_lo_in, vv_hi_in;
   logic signed [COORD_BITS-1:0] px, py;
   logic                         cross_hv, cross_vh, touch_hv, touch_vh;
   logic                         hh_over, vv_over, on_h, on_v;

   assign px = end_x[END_A2];
   assign py = end_y[END_A2];

   // perpendicular pairs: strict for a crossing, inclusive for a touch
   assign cross_hv = (leg_lo[LEG_H1] < leg_fix[LEG_V2]) && (leg_fix[LEG_V2] < leg_hi[LEG_H1]) &&
                     (leg_lo[LEG_V2] < leg_fix[LEG_H1]) && (leg_fix[LEG_H1] < leg_hi[LEG_V2]);
   assign cross_vh = (leg_lo[LEG_H2] < leg_fix[LEG_V1]) && (leg_fix[LEG_V1] < leg_hi[LEG_H2]) &&
                     (leg_lo[LEG_V1] < leg_fix[LEG_H2]) && (leg_fix[LEG_H2] < leg_hi[LEG_V1]);
   assign touch_hv = (leg_lo[LEG_H1] <= leg_fix[LEG_V2]) && (leg_fix[LEG_V2] <= leg_hi[LEG_H1]) &&
                     (leg_lo[LEG_V2] <= leg_fix[LEG_H1]) && (leg_fix[LEG_H1] <= leg_hi[LEG_V2]);
   assign touch_vh = (leg_lo[LEG_H2] <= leg_fix[LEG_V1]) && (leg_fix[LEG_V1] <= leg_hi[LEG_H2]) &&
                     (leg_lo[LEG_V1] <= leg_fix[LEG_H2]) && (leg_fix[LEG_H2] <= leg_hi[LEG_V1]);

   // collinear pairs with overlap of positive length
   assign hh_over = (leg_fix[LEG_H1] == leg_fix[LEG_H2]) &&
                    (leg_lo[LEG_H1] < leg_hi[LEG_H2]) && (leg_lo[LEG_H2] < leg_hi[LEG_H1]);
   assign vv_over = (leg_fix[LEG_V1] == leg_fix[LEG_V2]) &&
                    (leg_lo[LEG_V1] < leg_hi[LEG_V2]) && (leg_lo[LEG_V2] < leg_hi[LEG_V1]);

   // probe on the first route, ends included
   assign on_h = (py == leg_fix[LEG_H1]) && (px >= leg_lo[LEG_H1]) && (px <= leg_hi[LEG_H1]);
   assign on_v = (px == leg_fix[LEG_V1]) && (py >= leg_lo[LEG_V1]) && (py <= leg_hi[LEG_V1]);

   assign hh_lo_in = (leg_lo[LEG_H1] > leg_lo[LEG_H2]) ? leg_lo[LEG_H1] : leg_lo[LEG_H2];
   assign hh_hi_in = (leg_hi[LEG_H1] < leg_hi[LEG_H2]) ? leg_hi[LEG_H1] : leg_hi[LEG_H2];
   assign vv_lo_in = (leg_lo[LEG_V1] > leg_lo[LEG_V2]) ? leg_lo[LEG_V1] : leg_lo[LEG_V2];
   assign vv_hi_in = (leg_hi[LEG_V1] < leg_hi[LEG_V2]) ? leg_hi[LEG_V1] : leg_hi[LEG_V2];

   always_comb begin
      flags_in.any_cross    = cross_hv | cross_vh | hh_over | vv_over;
      flags_in.any_touch    = touch_hv | touch_vh;
      flags_in.probe_on_leg = on_h | on_v;
      flags_in.hh_same_line = (leg_fix[LEG_H1] == leg_fix[LEG_H2]);
      flags_in.vv_same_line = (leg_fix[LEG_V1] == leg_fix[LEG_V2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff       <= ctl_in;
         flags_ff     <= flags_in;
         node_x_ff[0] <= end_x[END_A1];
         node_y_ff[0] <= end_y[END_A1];
         node_x_ff[1] <= end_x[END_B1];
         node_y_ff[1] <= end_y[END_B1];
         hh_lo_ff     <= hh_lo_in;
         hh_hi_ff     <= hh_hi_in;
         vv_lo_ff     <= vv_lo_in;
         vv_hi_ff     <= vv_hi_in;
      end
   end

   assign ctl_out    = ctl_ff;
   assign flags_out  = flags_ff;
   assign node_x_out = node_x_ff;
   assign node_y_out = node_y_ff;
   assign hh_lo_out  = hh_lo_ff;
   assign hh_hi_out  = hh_hi_ff;
   assign vv_lo_out  = vv_lo_ff;
   assign vv_hi_out  = vv_hi_ff;

endmodule

// ----- verif/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrcc_pkg::*;

   // Action code the block takes but ignores; answers hit 0
   localparam logic [1:0] ACT_SPARE = 2'd3;
   // Cycles with no handshake on either channel before giving up
   localparam int QUIET_LIMIT = 4000;
   // Random requests per idling phase
   localparam int PHASE_REQUESTS = 225;
   // Settling time once the last response is in (pipe depth plus margin)
   localparam int DRAIN_CYCLES = 8;

   // One axis-parallel leg: pos is the fixed coordinate, lo..hi the span
   typedef struct {
      bit horiz;
      int pos;
      int lo;
      int hi;
   } leg_type;

   typedef struct {
      leg_type leg[2];
   } route_type;

   // Tracks the node table and the hit expected for each accepted request
   class route_hit_book_type;
      logic signed [15:0] node_x [64];
      logic signed [15:0] node_y [64];
      bit                 pending_hits[$];
      int                 mismatches;

      function route_type build_route(int a, int b, bit bend);
         route_type r;
         leg_type   h, v;
         int        xa, ya, xb, yb;
         xa = int'(node_x[a]);
         ya = int'(node_y[a]);
         xb = int'(node_x[b]);
         yb = int'(node_y[b]);
         h.horiz = 1'b1;
         h.lo    = (xa < xb) ? xa : xb;
         h.hi    = (xa < xb) ? xb : xa;
         v.horiz = 1'b0;
         v.lo    = (ya < yb) ? ya : yb;
         v.hi    = (ya < yb) ? yb : ya;
         if (!bend) begin
            h.pos    = ya;
            v.pos    = xb;
            r.leg[0] = h;
            r.leg[1] = v;
         end else begin
            v.pos    = xa;
            h.pos    = yb;
            r.leg[0] = v;
            r.leg[1] = h;
         end
         return r;
      endfunction

      // strict crossing, or collinear overlap of positive length
      function bit legs_cross(leg_type p, leg_type q);
         leg_type h, v;
         if (p.horiz != q.horiz) begin
            h = p.horiz ? p : q;
            v = p.horiz ? q : p;
            return h.lo < v.pos && v.pos < h.hi && v.lo < h.pos && h.pos < v.hi;
         end
         if (p.pos != q.pos) return 1'b0;
         return p.lo < q.hi && q.lo < p.hi;
      endfunction

      // perpendicular contact, ends included
      function bit legs_touch(leg_type p, leg_type q);
         leg_type h, v;
         if (p.horiz == q.horiz) return 1'b0;
         h = p.horiz ? p : q;
         v = p.horiz ? q : p;
         return h.lo <= v.pos && v.pos <= h.hi && v.lo <= h.pos && h.pos <= v.hi;
      endfunction

      function bit overlap_past_node(route_type r1, route_type r2, int s);
         int lo, hi, c;
         for (int m = 0; m < 2; m++) begin
            for (int n = 0; n < 2; n++) begin
               if (r1.leg[m].horiz != r2.leg[n].horiz) continue;
               if (r1.leg[m].pos != r2.leg[n].pos) continue;
               lo = (r1.leg[m].lo > r2.leg[n].lo) ? r1.leg[m].lo : r2.leg[n].lo;
               hi = (r1.leg[m].hi < r2.leg[n].hi) ? r1.leg[m].hi : r2.leg[n].hi;
               if (hi <= lo) continue;
               c = r1.leg[m].horiz ? int'(node_x[s]) : int'(node_y[s]);
               if (hi > c || lo < c) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit routes_conflict(int i, int j, bit b1, int k, int l, bit b2);
         route_type r1, r2;
         int        ends[4];
         bit        shared;
         r1 = build_route(i, j, b1);
         r2 = build_route(k, l, b2);
         shared = 1'b0;
         for (int m = 0; m < 2; m++)
            for (int n = 0; n < 2; n++)
               if (legs_cross(r1.leg[m], r2.leg[n])) return 1'b1;
         ends = '{i, j, k, l};
         foreach (ends[m]) begin
            if ((ends[m] == i || ends[m] == j) && (ends[m] == k || ends[m] == l)) begin
               shared = 1'b1;
               if (overlap_past_node(r1, r2, ends[m])) return 1'b1;
            end
         end
         if (shared) return 1'b0;
         for (int m = 0; m < 2; m++)
            for (int n = 0; n < 2; n++)
               if (legs_touch(r1.leg[m], r2.leg[n])) return 1'b1;
         return 1'b0;
      endfunction

      function bit route_covers_node(int i, int j, bit bend, int p);
         route_type r;
         int        px, py;
         px = int'(node_x[p]);
         py = int'(node_y[p]);
         if (p == i || p == j) return 1'b0;
         if (node_x[p] == node_x[i] && node_y[p] == node_y[i]) return 1'b0;
         if (node_x[p] == node_x[j] && node_y[p] == node_y[j]) return 1'b0;
         r = build_route(i, j, bend);
         for (int m = 0; m < 2; m++) begin
            if (r.leg[m].horiz) begin
               if (py == r.leg[m].pos && px >= r.leg[m].lo && px <= r.leg[m].hi)
                  return 1'b1;
            end else begin
               if (px == r.leg[m].pos && py >= r.leg[m].lo && py <= r.leg[m].hi)
                  return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic [1:0] act, logic [5:0] fa, logic [5:0] fb,
                                 logic fbend, logic [5:0] sa, logic [5:0] sb,
                                 logic sbend, logic signed [15:0] lx,
                                 logic signed [15:0] ly);
         bit hit;
         hit = 1'b0;
         case (act)
            ACT_LOAD: begin
               node_x[fa] = lx;
               node_y[fa] = ly;
            end
            ACT_CROSS: hit = routes_conflict(int'(fa), int'(fb), fbend,
                                             int'(sa), int'(sb), sbend);
            ACT_PASS:  hit = route_covers_node(int'(fa), int'(fb), fbend, int'(sa));
            default:   hit = 1'b0;
         endcase
         pending_hits = {pending_hits, hit};
      endfunction

      function void check_hit(logic hit);
         bit want;
         if (pending_hits.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, actual hit %b",
                     $time, hit);
            mismatches++;
            return;
         end
         want = pending_hits.pop_front();
         if (hit !== want) begin
            $display("%0t: rsp_hit mismatch: expected %b, actual %b", $time, want, hit);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_hits.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_LOAD;
   logic [5:0]         req_first_a = '0;
   logic [5:0]         req_first_b = '0;
   logic               req_first_bend = 1'b0;
   logic [5:0]         req_second_a = '0;
   logic [5:0]         req_second_b = '0;
   logic               req_second_bend = 1'b0;
   logic signed [15:0] req_load_x = '0;
   logic signed [15:0] req_load_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;

   route_hit_book_type book = new();

   // idling odds, in cycles out of a hundred
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   // nodes written so far; queries only ever name these
   bit         loaded [64];
   logic [5:0] loaded_list[$];

   lshape_route_crossing_check_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_first_a     (req_first_a),
      .req_first_b     (req_first_b),
      .req_first_bend  (req_first_bend),
      .req_second_a    (req_second_a),
      .req_second_b    (req_second_b),
      .req_second_bend (req_second_bend),
      .req_load_x      (req_load_x),
      .req_load_y      (req_load_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // both channels observed at the rising edge, before the block updates
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) book.check_hit(rsp_hit);
         if (req_valid && req_ready)
            book.note_request(req_action, req_first_a, req_first_b, req_first_bend,
                              req_second_a, req_second_b, req_second_bend,
                              req_load_x, req_load_y);
      end
   end

   // watchdog: any stretch without a handshake this long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one request at a falling edge, holds it until taken.
   // Entered and left at a falling edge; valid is left high.
   task automatic send_request(logic [1:0] act, logic [5:0] fa, logic [5:0] fb,
                               logic fbend, logic [5:0] sa, logic [5:0] sb,
                               logic sbend, logic signed [15:0] lx,
                               logic signed [15:0] ly);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action      = act;
      req_first_a     = fa;
      req_first_b     = fb;
      req_first_bend  = fbend;
      req_second_a    = sa;
      req_second_b    = sb;
      req_second_bend = sbend;
      req_load_x      = lx;
      req_load_y      = ly;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_node(logic [5:0] idx, logic signed [15:0] x,
                            logic signed [15:0] y);
      logic [5:0] other;
      // spare index fields point at a written node whenever one exists
      other = (loaded_list.size() != 0) ? loaded_list[0] : idx;
      send_request(ACT_LOAD, idx, other, 1'($urandom_range(1)), other, other,
                   1'($urandom_range(1)), x, y);
      if (!loaded[idx]) begin
         loaded[idx] = 1'b1;
         loaded_list = {loaded_list, idx};
      end
   endtask

   task automatic cross_query(logic [5:0] fa, logic [5:0] fb, logic fbend,
                              logic [5:0] sa, logic [5:0] sb, logic sbend);
      send_request(ACT_CROSS, fa, fb, fbend, sa, sb, sbend, 16'($urandom), 16'($urandom));
   endtask

   task automatic pass_query(logic [5:0] fa, logic [5:0] fb, logic bend,
                             logic [5:0] probe);
      send_request(ACT_PASS, fa, fb, bend, probe, fa, 1'($urandom_range(1)),
                   16'($urandom), 16'($urandom));
   endtask

   function automatic logic [5:0] some_node();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // mostly a small grid so positions coincide; extremes and full range now and then
   function automatic logic signed [15:0] some_coord();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'($urandom);
         default: return 16'(int'($urandom_range(6)) - 3);
      endcase
   endfunction

   task automatic random_request();
      int         pick;
      logic [5:0] fa, fb, sa, sb;
      logic       fbend, sbend;
      pick  = $urandom_range(99);
      fa    = some_node();
      fb    = some_node();
      sa    = some_node();
      sb    = some_node();
      fbend = 1'($urandom_range(1));
      sbend = 1'($urandom_range(1));
      if (pick < 25) begin
         load_node(6'($urandom_range(63)), some_coord(), some_coord());
      end else if (pick < 28) begin
         send_request(ACT_SPARE, fa, fb, fbend, sa, sb, sbend, 16'($urandom), 16'($urandom));
      end else if (pick < 65) begin
         if ($urandom_range(9) == 0) fb = fa;   // zero-length route now and then
         // routes sharing an end take the special shared-node rule
         if ($urandom_range(9) < 4) begin
            case ($urandom_range(4))
               0: sa = fa;
               1: sa = fb;
               2: sb = fa;
               3: sb = fb;
               default: begin
                  sa = fb;
                  sb = fa;
               end
            endcase
         end
         cross_query(fa, fb, fbend, sa, sb, sbend);
      end else begin
         if ($urandom_range(99) < 15) sa = $urandom_range(1) ? fa : fb;
         send_request(ACT_PASS, fa, fb, fbend, sa, sb, sbend, 16'($urandom), 16'($urandom));
      end
   endtask

   // hold off until every response is back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(int idle, int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (PHASE_REQUESTS) random_request();
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners of the coordinate range
      load_node(6'd0,  16'sh8000, 16'sh8000);
      load_node(6'd63, 16'sh7fff, 16'sh7fff);
      load_node(6'd1,  16'sh8000, 16'sh7fff);
      load_node(6'd2,  16'sh7fff, 16'sh8000);
      // a small square with points on and around its edges
      load_node(6'd3,  16'sd0, 16'sd0);
      load_node(6'd4,  16'sd4, 16'sd0);
      load_node(6'd5,  16'sd0, 16'sd4);
      load_node(6'd6,  16'sd4, 16'sd4);
      load_node(6'd7,  16'sd2, -16'sd2);
      load_node(6'd8,  16'sd2, 16'sd6);
      load_node(6'd9,  16'sd2, 16'sd0);
      load_node(6'd10, 16'sd4, 16'sd0);       // same spot as node 4

      cross_query(6'd0, 6'd63, 1'b0, 6'd1, 6'd2, 1'b0);  // full-span collinear legs
      cross_query(6'd0, 6'd63, 1'b1, 6'd1, 6'd2, 1'b1);
      cross_query(6'd7, 6'd8, 1'b0, 6'd3, 6'd6, 1'b0);   // proper crossing
      cross_query(6'd3, 6'd4, 1'b0, 6'd9, 6'd8, 1'b1);   // T touch, no shared end
      cross_query(6'd3, 6'd4, 1'b0, 6'd3, 6'd9, 1'b0);   // shared end, overlap along y=0
      cross_query(6'd3, 6'd4, 1'b0, 6'd3, 6'd5, 1'b1);   // shared end, corner touch only
      cross_query(6'd4, 6'd3, 1'b1, 6'd5, 6'd3, 1'b0);
      cross_query(6'd9, 6'd9, 1'b0, 6'd3, 6'd4, 1'b0);   // zero-length route on a leg
      pass_query(6'd3, 6'd4, 1'b0, 6'd9);                 // probe mid-leg
      pass_query(6'd3, 6'd4, 1'b0, 6'd10);                // probe sits on an end
      pass_query(6'd3, 6'd4, 1'b0, 6'd3);                 // probe is an end
      pass_query(6'd3, 6'd6, 1'b1, 6'd5);                 // probe at the bend
      send_request(ACT_SPARE, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63, 1'b1,
                   16'sh7fff, 16'sh8000);
      // a load is seen by the very next request
      load_node(6'd11, 16'sd2, 16'sd0);
      pass_query(6'd3, 6'd4, 1'b0, 6'd11);
      wait_drained();

      // random traffic under each idling pattern; each phase drains fully
      run_phase(0, 0);
      run_phase(87, 0);
      run_phase(0, 87);
      run_phase(29, 29);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
